// ===== src/nmt_slave_heartbeat_producer_core_macros.svh =====
// ----------------------------------------------------------------------------
// NMT slave heartbeat producer assertion macros
// Shared concurrent assertion forms. They compile to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef NMT_SLAVE_HEARTBEAT_PRODUCER_CORE_MACROS_SVH
`define NMT_SLAVE_HEARTBEAT_PRODUCER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define NMTHB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nmthb assertion failed");
`define NMTHB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nmthb assertion failed");
`else
`define NMTHB_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define NMTHB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/nmthb_pkg.sv =====
// ----------------------------------------------------------------------------
// NMT slave heartbeat producer package
// Shared codes, constants and the record passed from front to back.
// ----------------------------------------------------------------------------
package nmthb_pkg;

	localparam int QueueDepth = 2;
	localparam int DivSteps   = 32;

	localparam logic [1:0] OPC_TICK  = 2'd0;
	localparam logic [1:0] OPC_FRAME = 2'd1;
	localparam logic [1:0] OPC_CMD   = 2'd2;

	localparam logic [7:0] CS_START      = 8'h01;
	localparam logic [7:0] CS_STOP       = 8'h02;
	localparam logic [7:0] CS_PREOP      = 8'h80;
	localparam logic [7:0] CS_RESET_NODE = 8'h81;
	localparam logic [7:0] CS_RESET_COMM = 8'h82;

	localparam logic [6:0] ST_INIT        = 7'd0;
	localparam logic [6:0] ST_STOPPED     = 7'd4;
	localparam logic [6:0] ST_OPERATIONAL = 7'd5;
	localparam logic [6:0] ST_PREOP       = 7'd127;

	localparam logic [1:0] EV_NONE       = 2'd0;
	localparam logic [1:0] EV_STATE      = 2'd1;
	localparam logic [1:0] EV_RESET_NODE = 2'd2;
	localparam logic [1:0] EV_RESET_COMM = 2'd3;

	localparam logic [10:0] HB_BASE = 11'h700;
	localparam logic [3:0]  NMT_DLC = 4'd2;

	localparam logic CFG_NODE_ID = 1'b0;
	localparam logic CFG_PERIOD  = 1'b1;

	typedef enum logic [1:0] {
		K_NONE,
		K_TICK,
		K_CMD
	} kind_t;

	typedef enum logic [2:0] {
		C_START,
		C_STOP,
		C_PREOP,
		C_RESET_NODE,
		C_RESET_COMM
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		cmd_t        cmd;
		logic [31:0] elapsed;
	} item_t;

endpackage

// ===== src/nmthb_front.sv =====
// ----------------------------------------------------------------------------
// NMT heartbeat front end
// Filters received frames and decodes commands into a compact record.
// ----------------------------------------------------------------------------
module nmthb_front (
	input  logic [1:0]         opcode,
	input  logic [31:0]        tick_ms,
	input  logic [10:0]        frame_id,
	input  logic               frame_extended,
	input  logic               frame_remote,
	input  logic [3:0]         frame_length,
	input  logic [7:0]         byte0,
	input  logic [7:0]         byte1,
	input  logic [6:0]         node_id,
	output nmthb_pkg::item_t   item
);
	import nmthb_pkg::*;

	logic frame_ok;
	logic cmd_known;
	cmd_t cmd;

	always_comb begin
		frame_ok = !frame_extended && !frame_remote && (frame_id == '0) &&
			(frame_length == NMT_DLC) &&
			((byte1 == 8'd0) || (byte1 == {1'b0, node_id}));
	end

	always_comb begin
		cmd_known = 1'b1;
		cmd       = C_START;
		unique case (byte0)
			CS_START:      cmd = C_START;
			CS_STOP:       cmd = C_STOP;
			CS_PREOP:      cmd = C_PREOP;
			CS_RESET_NODE: cmd = C_RESET_NODE;
			CS_RESET_COMM: cmd = C_RESET_COMM;
			default:       cmd_known = 1'b0;
		endcase
	end

	always_comb begin
		item.kind    = K_NONE;
		item.cmd     = cmd;
		item.elapsed = tick_ms;
		unique case (opcode)
			OPC_TICK:  item.kind = K_TICK;
			OPC_FRAME: item.kind = (frame_ok && cmd_known) ? K_CMD : K_NONE;
			OPC_CMD:   item.kind = cmd_known ? K_CMD : K_NONE;
			default:   item.kind = K_NONE;
		endcase
	end

endmodule

// ===== src/nmthb_queue.sv =====
// ----------------------------------------------------------------------------
// NMT heartbeat item queue
// Small FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module nmthb_queue #(
	parameter int DEPTH = nmthb_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  nmthb_pkg::item_t wr_item,
	output logic             full,
	input  logic             rd_en,
	output nmthb_pkg::item_t rd_item,
	output logic             rd_valid
);
	import nmthb_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr;
	logic           do_rd;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/nmthb_back.sv =====
// ----------------------------------------------------------------------------
// NMT heartbeat back end
// Holds the NMT state, the boot-up flag and the heartbeat accumulator,
// reduces the accumulator with a bit-serial remainder unit and keeps the
// result register.
// ----------------------------------------------------------------------------
module nmthb_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [6:0]       node_id,
	input  logic [31:0]      heartbeat_period,
	input  logic             q_valid,
	input  nmthb_pkg::item_t q_item,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [1:0]       event_res,
	output logic             hb_valid,
	output logic [10:0]      hb_id,
	output logic [6:0]       hb_state,
	output logic [6:0]       node_state
);
	import nmthb_pkg::*;

	localparam int SW = $clog2(DivSteps);

	typedef enum logic {
		S_IDLE,
		S_DIV
	} fsm_t;

	fsm_t          fsm_q;
	logic [6:0]    nmt_q;
	logic          bootup_q;
	logic [31:0]   acc_q;
	logic [31:0]   num_q;
	logic [31:0]   rem_q;
	logic [SW-1:0] step_q;
	logic [6:0]    hb_st_q;
	logic          res_valid_q;
	logic [1:0]    ev_q;
	logic          hbv_q;
	logic [10:0]   hbid_q;
	logic [6:0]    hbst_q;

	logic          slot_free;
	logic [32:0]   sum_w;
	logic [31:0]   sat_w;
	logic [32:0]   shl_w;
	logic [32:0]   sub_w;
	logic [31:0]   rem_next;
	logic [10:0]   hb_id_w;

	assign slot_free  = !res_valid_q || pop;
	assign q_pop      = (fsm_q == S_IDLE) && q_valid && slot_free;
	assign empty      = !res_valid_q;
	assign event_res  = ev_q;
	assign hb_valid   = hbv_q;
	assign hb_id      = hbid_q;
	assign hb_state   = hbst_q;
	assign node_state = nmt_q;

	assign sum_w    = {1'b0, acc_q} + {1'b0, q_item.elapsed};
	assign sat_w    = sum_w[32] ? '1 : sum_w[31:0];
	assign shl_w    = {rem_q, num_q[31]};
	assign sub_w    = shl_w - {1'b0, heartbeat_period};
	assign rem_next = sub_w[32] ? shl_w[31:0] : sub_w[31:0];
	assign hb_id_w  = HB_BASE + {4'b0, node_id};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= S_IDLE;
			nmt_q       <= ST_INIT;
			bootup_q    <= 1'b1;
			acc_q       <= '0;
			num_q       <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			hb_st_q     <= ST_INIT;
			res_valid_q <= 1'b0;
			ev_q        <= EV_NONE;
			hbv_q       <= 1'b0;
			hbid_q      <= '0;
			hbst_q      <= '0;
		end else begin
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			unique case (fsm_q)
				S_IDLE: begin
					if (q_pop) begin
						res_valid_q <= 1'b1;
						ev_q        <= EV_NONE;
						hbv_q       <= 1'b0;
						hbid_q      <= '0;
						hbst_q      <= '0;
						unique case (q_item.kind)
							K_TICK: begin
								if (bootup_q) begin
									hbv_q    <= 1'b1;
									hbid_q   <= hb_id_w;
									hbst_q   <= ST_INIT;
									bootup_q <= 1'b0;
									nmt_q    <= ST_PREOP;
									acc_q    <= '0;
								end else if (heartbeat_period != '0) begin
									if (sat_w >= heartbeat_period) begin
										res_valid_q <= 1'b0;
										num_q       <= sat_w;
										rem_q       <= '0;
										step_q      <= '0;
										hb_st_q     <= nmt_q;
										fsm_q       <= S_DIV;
									end else begin
										acc_q <= sat_w;
									end
								end
							end
							K_CMD: begin
								unique case (q_item.cmd)
									C_START: begin
										nmt_q <= ST_OPERATIONAL;
										ev_q  <= EV_STATE;
									end
									C_STOP: begin
										nmt_q <= ST_STOPPED;
										ev_q  <= EV_STATE;
									end
									C_PREOP: begin
										nmt_q <= ST_PREOP;
										ev_q  <= EV_STATE;
									end
									C_RESET_NODE, C_RESET_COMM: begin
										nmt_q    <= ST_INIT;
										acc_q    <= '0;
										bootup_q <= 1'b1;
										ev_q     <= (q_item.cmd == C_RESET_NODE) ?
											EV_RESET_NODE : EV_RESET_COMM;
									end
									default: ev_q <= EV_NONE;
								endcase
							end
							default: ev_q <= EV_NONE;
						endcase
					end
				end
				S_DIV: begin
					rem_q  <= rem_next;
					num_q  <= {num_q[30:0], 1'b0};
					step_q <= step_q + 1'b1;
					if (step_q == SW'(DivSteps - 1)) begin
						acc_q       <= rem_next;
						res_valid_q <= 1'b1;
						hbv_q       <= 1'b1;
						hbid_q      <= hb_id_w;
						hbst_q      <= hb_st_q;
						fsm_q       <= S_IDLE;
					end
				end
				default: fsm_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/nmt_slave_heartbeat_producer_core.sv =====
// ----------------------------------------------------------------------------
// NMT slave heartbeat producer core
// Items enter through push/full: a tick, a received NMT frame or a local
// command. The front end filters and decodes each item into a two-entry
// queue; the back end updates the NMT state and heartbeat accumulator and
// places exactly one result per item into a result register read through
// empty/pop. The configuration channel (cfg_valid/cfg_ready) writes the
// node id (index 0) and heartbeat period (index 1); it is always ready.
// An accepted item waits in the queue until the back end takes it and
// registers its result. A tick that makes a heartbeat due runs a
// bit-serial remainder of the accumulator by the period, one bit a cycle,
// and its result is registered once the remainder unit is done; other
// items skip the remainder unit. While the result register is not popped,
// the back end holds and the queue fills; full rises once two items wait.
// Reset returns the node to initialization with boot-up pending, period 0
// and node id 1.
// ----------------------------------------------------------------------------
`include "nmt_slave_heartbeat_producer_core_macros.svh"

module nmt_slave_heartbeat_producer_core #(
	parameter int QUEUE_DEPTH = nmthb_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [31:0] tick_ms,
	input  logic [10:0] frame_id,
	input  logic        frame_extended,
	input  logic        frame_remote,
	input  logic [3:0]  frame_length,
	input  logic [7:0]  byte0,
	input  logic [7:0]  byte1,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  event_res,
	output logic        hb_valid,
	output logic [10:0] hb_id,
	output logic [6:0]  hb_state,
	output logic [6:0]  node_state,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import nmthb_pkg::*;

	logic [6:0]  node_id_q;
	logic [31:0] period_q;
	item_t       front_item;
	item_t       q_item;
	logic        q_valid;
	logic        q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= 7'd1;
			period_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NODE_ID: node_id_q <= cfg_data[6:0];
				CFG_PERIOD:  period_q  <= cfg_data;
				default:     period_q  <= period_q;
			endcase
		end
	end

	nmthb_front u_front (
		.opcode         (opcode),
		.tick_ms        (tick_ms),
		.frame_id       (frame_id),
		.frame_extended (frame_extended),
		.frame_remote   (frame_remote),
		.frame_length   (frame_length),
		.byte0          (byte0),
		.byte1          (byte1),
		.node_id        (node_id_q),
		.item           (front_item)
	);

	nmthb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_item  (front_item),
		.full     (full),
		.rd_en    (q_pop),
		.rd_item  (q_item),
		.rd_valid (q_valid)
	);

	nmthb_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.node_id          (node_id_q),
		.heartbeat_period (period_q),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.q_pop            (q_pop),
		.empty            (empty),
		.pop              (pop),
		.event_res        (event_res),
		.hb_valid         (hb_valid),
		.hb_id            (hb_id),
		.hb_state         (hb_state),
		.node_state       (node_state)
	);

	`NMTHB_ASSERT_NOW(a_idle_frame_zero, clk, arst_n, !empty && !hb_valid,
		hb_id == '0 && hb_state == '0)
	`NMTHB_ASSERT_NOW(a_hb_id_base, clk, arst_n, !empty && hb_valid,
		hb_id[10:8] == 3'b111)
	`NMTHB_ASSERT_NOW(a_event_no_hb, clk, arst_n, !empty && event_res != EV_NONE,
		!hb_valid)
	`NMTHB_ASSERT_NOW(a_state_code, clk, arst_n, 1'b1,
		node_state == ST_INIT || node_state == ST_STOPPED ||
		node_state == ST_OPERATIONAL || node_state == ST_PREOP)

endmodule
